// ===== rtl/csc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants for the CORDIC sine/cosine pipeline.
// ----------------------------------------------------------------------------
package csc_pkg;

  // Width of the range reduction datapath (angle * 4 plus one wrap)
  localparam int RED_W = 36;
  // Width of the residual angle through the micro-rotations, Q.30
  localparam int Z_W   = 34;
  // Number of arctangent entries available
  localparam int TABLE_LEN = 30;

  localparam logic signed [RED_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [RED_W-1:0] TWO_PI_Q30  = 36'sd6746518853;
  localparam logic signed [RED_W-1:0] HALF_PI_Q30 = 36'sd1686629713;

  // floor(atan(2^-i) * 2^30)
  localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
    32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
    32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127,       32'd63,
    32'd31,        32'd15,        32'd7,         32'd3,         32'd1
  };

  // Control bits that travel alongside each item in the pipe
  typedef struct packed {
    logic valid;
    logic negate;
  } ctl_t;

  // Round-half-up of K * 2^frac, K = 0.60725293500888, by long division.
  // Only used at elaboration.
  function automatic longint unsigned gain_start(input int frac);
    longint unsigned r;
    longint unsigned q;
    r = 64'd60725293500888;
    q = 64'd0;
    for (int k = 0; k < frac + 1; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= 64'd100000000000000) begin
        r = r - 64'd100000000000000;
        q = q | 64'd1;
      end
    end
    return (q + 64'd1) >> 1;
  endfunction

endpackage : csc_pkg
`default_nettype wire

// ===== rtl/csc_reduce.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_reduce
// Two-stage range reduction: one 2*pi wrap, then a half-plane fold by pi.
// ----------------------------------------------------------------------------
module csc_reduce (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic signed [31:0]            angle_i,
  output csc_pkg::ctl_t                      ctl_o,
  output logic signed [csc_pkg::Z_W-1:0]     z_o
);
  import csc_pkg::*;

  logic                    wrap_valid_q;
  logic signed [RED_W-1:0] wrap_z_d, wrap_z_q;
  logic signed [RED_W-1:0] z0;
  logic signed [RED_W-1:0] fold_z;
  ctl_t                    ctl_d, ctl_q;
  logic signed [Z_W-1:0]   z_d, z_q;

  // Stage 1: Q4.28 -> Q.30 and single wrap
  always_comb begin
    z0 = RED_W'(angle_i) <<< 2;
    if (z0 >= PI_Q30) begin
      wrap_z_d = z0 - TWO_PI_Q30;
    end else if (z0 < -PI_Q30) begin
      wrap_z_d = z0 + TWO_PI_Q30;
    end else begin
      wrap_z_d = z0;
    end
  end

  // Stage 2: fold outer half-planes by pi, results negated at the end
  always_comb begin
    ctl_d.valid  = wrap_valid_q;
    ctl_d.negate = 1'b0;
    fold_z       = wrap_z_q;
    if (wrap_z_q >= HALF_PI_Q30) begin
      fold_z       = wrap_z_q - PI_Q30;
      ctl_d.negate = 1'b1;
    end else if (wrap_z_q < -HALF_PI_Q30) begin
      fold_z       = wrap_z_q + PI_Q30;
      ctl_d.negate = 1'b1;
    end
    z_d = fold_z[Z_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_valid_q <= 1'b0;
      ctl_q        <= '0;
    end else if (en_i) begin
      wrap_valid_q <= valid_i;
      ctl_q        <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wrap_z_q <= wrap_z_d;
      z_q      <= z_d;
    end
  end

  assign ctl_o = ctl_q;
  assign z_o   = z_q;

endmodule : csc_reduce
`default_nettype wire

// ===== rtl/csc_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_stage
// One registered CORDIC micro-rotation with fixed shift IDX.
// ----------------------------------------------------------------------------
module csc_stage #(
  parameter int XW  = 34,
  parameter int IDX = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire csc_pkg::ctl_t                 ctl_i,
  input  wire logic signed [XW-1:0]          x_i,
  input  wire logic signed [XW-1:0]          y_i,
  input  wire logic signed [csc_pkg::Z_W-1:0] z_i,
  output csc_pkg::ctl_t                      ctl_o,
  output logic signed [XW-1:0]               x_o,
  output logic signed [XW-1:0]               y_o,
  output logic signed [csc_pkg::Z_W-1:0]     z_o
);
  import csc_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN_I = Z_W'(ATAN_Q30[IDX]);

  logic signed [XW-1:0]  xs, ys;
  logic signed [XW-1:0]  x_d, y_d, x_q, y_q;
  logic signed [Z_W-1:0] z_d, z_q;
  ctl_t                  ctl_q;

  always_comb begin
    xs = x_i >>> IDX;
    ys = y_i >>> IDX;
    if (z_i < 0) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN_I;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN_I;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule : csc_stage
`default_nettype wire

// ===== rtl/csc_outfmt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_outfmt
// Quadrant negate, Q2.F to Q2.30 conversion with saturation, output register.
// ----------------------------------------------------------------------------
module csc_outfmt #(
  parameter int XW   = 34,
  parameter int FRAC = 30
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire csc_pkg::ctl_t        ctl_i,
  input  wire logic signed [XW-1:0] x_i,
  input  wire logic signed [XW-1:0] y_i,
  output logic                      valid_o,
  output logic signed [31:0]        cosine_out_o,
  output logic signed [31:0]        sine_out_o
);
  import csc_pkg::*;

  localparam int CW = XW + 32;
  localparam logic signed [CW-1:0] SAT_HI = CW'(64'sd2147483647);
  localparam logic signed [CW-1:0] SAT_LO = CW'(-64'sd2147483648);

  logic signed [XW-1:0] xn, yn;
  logic signed [CW-1:0] xe, ye;
  logic signed [CW-1:0] xr, yr;
  logic signed [31:0]   cos_d, sin_d, cos_q, sin_q;
  logic                 valid_q;

  function automatic logic signed [31:0] sat32(input logic signed [CW-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    xn = ctl_i.negate ? -x_i : x_i;
    yn = ctl_i.negate ? -y_i : y_i;
    xe = CW'(xn);
    ye = CW'(yn);
  end

  generate
    if (FRAC > 30) begin : g_round
      localparam int SH = FRAC - 30;
      localparam logic signed [CW-1:0] HALF = CW'(1) <<< (SH - 1);
      assign xr = (xe + HALF) >>> SH;
      assign yr = (ye + HALF) >>> SH;
    end else begin : g_widen
      localparam int SH = 30 - FRAC;
      assign xr = xe <<< SH;
      assign yr = ye <<< SH;
    end
  endgenerate

  assign cos_d = sat32(xr);
  assign sin_d = sat32(yr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  assign valid_o      = valid_q;
  assign cosine_out_o = cos_q;
  assign sine_out_o   = sin_q;

endmodule : csc_outfmt
`default_nettype wire

// ===== rtl/cordic_sine_cosine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cordic_sine_cosine
// Rotation-mode CORDIC: angle (Q4.28 rad) in, cosine and sine (Q2.30) out.
//
// Input channel: in_valid_i / in_stall_o with angle_i. A transfer happens on
// a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with cosine_out_o, sine_out_o.
// Throughput: one angle per cycle, back to back, while no valid result is
// stalled; one result per angle. From input transfer to out_valid_o an
// angle passes two range reduction stages, one stage per micro-rotation
// and one output format stage. Results leave in input order.
// When the receiver stalls a valid result, the whole pipe holds in place
// and in_stall_o goes high the same cycle; nothing is dropped or repeated.
// Bubbles in the pipe keep moving while no valid result is held.
// Reset clears all valid bits; the pipe is empty and ready right after.
// ----------------------------------------------------------------------------
module cordic_sine_cosine #(
  parameter int ITERATIONS = 28,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] angle_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      cosine_out_o,
  output logic signed [31:0]      sine_out_o
);
  import csc_pkg::*;

  localparam int N    = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
  localparam int FRAC = DATA_WIDTH - 2;
  // Two guard bits above Q2.F
  localparam int XW   = DATA_WIDTH + 2;
  localparam logic signed [XW-1:0] X_INIT = XW'(gain_start(FRAC));

  logic                  en;
  ctl_t                  ctl_s [N+1];
  logic signed [XW-1:0]  x_s   [N+1];
  logic signed [XW-1:0]  y_s   [N+1];
  logic signed [Z_W-1:0] z_s   [N+1];

  // Pipe advances unless a finished result is held by the receiver
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  csc_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .angle_i (angle_i),
    .ctl_o   (ctl_s[0]),
    .z_o     (z_s[0])
  );

  assign x_s[0] = X_INIT;
  assign y_s[0] = '0;

  generate
    for (genvar k = 0; k < N; k++) begin : g_iter
      csc_stage #(
        .XW  (XW),
        .IDX (k)
      ) u_stage (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .ctl_i  (ctl_s[k]),
        .x_i    (x_s[k]),
        .y_i    (y_s[k]),
        .z_i    (z_s[k]),
        .ctl_o  (ctl_s[k+1]),
        .x_o    (x_s[k+1]),
        .y_o    (y_s[k+1]),
        .z_o    (z_s[k+1])
      );
    end
  endgenerate

  csc_outfmt #(
    .XW   (XW),
    .FRAC (FRAC)
  ) u_outfmt (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .ctl_i        (ctl_s[N]),
    .x_i          (x_s[N]),
    .y_i          (y_s[N]),
    .valid_o      (out_valid_o),
    .cosine_out_o (cosine_out_o),
    .sine_out_o   (sine_out_o)
  );

endmodule : cordic_sine_cosine
`default_nettype wire
